// ===== rtl/core/slu_pkg.sv =====
// shared types and character codes for the string literal unescaper
package slu_pkg;

	// scanner modes
	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_BODY = 2'd1,
		MODE_ESC  = 2'd2,
		MODE_HEX  = 2'd3
	} mode_t;

	// character codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LC_U   = 8'h75;
	localparam logic [7:0] CH_LC_N   = 8'h6E;
	localparam logic [7:0] CH_LC_T   = 8'h74;
	localparam logic [7:0] CH_LC_R   = 8'h72;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	// modified utf-8 lead and continuation marks
	localparam logic [7:0] UTF_LEAD2 = 8'hC0;
	localparam logic [7:0] UTF_LEAD3 = 8'hE0;
	localparam logic [7:0] UTF_CONT  = 8'h80;

	// one queued command: up to three result items of the same kind
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [1:0] last_idx;
		logic       byte_valid;
		logic       string_done;
		logic       bad_start;
	} cmd_t;

endpackage

// ===== rtl/core/slu_front.sv =====
// front end: accepts source bytes, runs the escape scanner, emits commands
module slu_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [7:0]    in_char,
	input  logic          q_full,
	output logic          push,
	output slu_pkg::cmd_t push_cmd
);
	import slu_pkg::*;

	mode_t       mode_q, mode_d;
	logic [1:0]  digits_q, digits_d;
	logic [15:0] acc_q, acc_d;
	logic        stopped_q, stopped_d;

	logic        accept;
	logic        dig_ok;
	logic [3:0]  dig_val;
	logic [15:0] acc_nx;
	logic        stop_nx;
	logic [7:0]  esc_byte;

	assign in_stall = q_full;
	assign accept   = in_valid & ~q_full;

	// hex digit decode
	always_comb begin
		dig_ok  = 1'b1;
		dig_val = 4'd0;
		if (in_char >= 8'h30 && in_char <= 8'h39) begin
			dig_val = 4'(in_char - 8'h30);
		end else if (in_char >= 8'h61 && in_char <= 8'h66) begin
			dig_val = 4'(in_char - 8'h57);
		end else if (in_char >= 8'h41 && in_char <= 8'h46) begin
			dig_val = 4'(in_char - 8'h37);
		end else begin
			dig_ok = 1'b0;
		end
	end

	// hex accumulator update for one field byte
	assign acc_nx  = (!stopped_q && dig_ok) ? {acc_q[11:0], dig_val} : acc_q;
	assign stop_nx = stopped_q | ~dig_ok;

	// simple escape mapping
	always_comb begin
		case (in_char)
			CH_LC_N: esc_byte = CH_LF;
			CH_LC_T: esc_byte = CH_TAB;
			CH_LC_R: esc_byte = CH_CR;
			default: esc_byte = in_char;
		endcase
	end

	// next state
	always_comb begin
		mode_d    = mode_q;
		digits_d  = digits_q;
		acc_d     = acc_q;
		stopped_d = stopped_q;
		if (accept) begin
			case (mode_q)
				MODE_IDLE: begin
					if (in_char == CH_QUOTE) mode_d = MODE_BODY;
				end
				MODE_BODY: begin
					if (in_char == CH_NUL || in_char == CH_QUOTE) mode_d = MODE_IDLE;
					else if (in_char == CH_BSLASH) mode_d = MODE_ESC;
				end
				MODE_ESC: begin
					if (in_char == CH_NUL) begin
						mode_d = MODE_IDLE;
					end else if (in_char == CH_LC_U) begin
						digits_d  = 2'd0;
						acc_d     = 16'd0;
						stopped_d = 1'b0;
						mode_d    = MODE_HEX;
					end else begin
						mode_d = MODE_BODY;
					end
				end
				MODE_HEX: begin
					if (in_char == CH_NUL) begin
						mode_d = MODE_IDLE;
					end else begin
						acc_d     = acc_nx;
						stopped_d = stop_nx;
						if (digits_q == 2'd3) begin
							digits_d = 2'd0;
							mode_d   = MODE_BODY;
						end else begin
							digits_d = digits_q + 2'd1;
						end
					end
				end
				default: mode_d = MODE_IDLE;
			endcase
		end
	end

	// command output
	always_comb begin
		push     = 1'b0;
		push_cmd = '0;
		case (mode_q)
			MODE_IDLE: begin
				if (in_char != CH_QUOTE) begin
					push               = accept;
					push_cmd.bad_start = 1'b1;
				end
			end
			MODE_BODY: begin
				if (in_char == CH_NUL || in_char == CH_QUOTE) begin
					push                 = accept;
					push_cmd.string_done = 1'b1;
				end else if (in_char != CH_BSLASH) begin
					push                = accept;
					push_cmd.b0         = in_char;
					push_cmd.byte_valid = 1'b1;
				end
			end
			MODE_ESC: begin
				if (in_char == CH_NUL) begin
					push                 = accept;
					push_cmd.string_done = 1'b1;
				end else if (in_char != CH_LC_U) begin
					push                = accept;
					push_cmd.b0         = esc_byte;
					push_cmd.byte_valid = 1'b1;
				end
			end
			MODE_HEX: begin
				if (in_char == CH_NUL) begin
					push                 = accept;
					push_cmd.string_done = 1'b1;
				end else if (digits_q == 2'd3) begin
					push                = accept;
					push_cmd.byte_valid = 1'b1;
					// encode the finished code point
					if (acc_nx < 16'h0080) begin
						if (acc_nx == 16'h0000) begin
							push_cmd.b0       = UTF_LEAD2;
							push_cmd.b1       = UTF_CONT;
							push_cmd.last_idx = 2'd1;
						end else begin
							push_cmd.b0 = acc_nx[7:0];
						end
					end else if (acc_nx < 16'h0800) begin
						push_cmd.b0       = UTF_LEAD2 | {3'd0, acc_nx[10:6]};
						push_cmd.b1       = UTF_CONT | {2'd0, acc_nx[5:0]};
						push_cmd.last_idx = 2'd1;
					end else begin
						push_cmd.b0       = UTF_LEAD3 | {4'd0, acc_nx[15:12]};
						push_cmd.b1       = UTF_CONT | {2'd0, acc_nx[11:6]};
						push_cmd.b2       = UTF_CONT | {2'd0, acc_nx[5:0]};
						push_cmd.last_idx = 2'd2;
					end
				end
			end
			default: push = 1'b0;
		endcase
	end

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			digits_q  <= 2'd0;
			acc_q     <= 16'd0;
			stopped_q <= 1'b0;
		end else begin
			mode_q    <= mode_d;
			digits_q  <= digits_d;
			acc_q     <= acc_d;
			stopped_q <= stopped_d;
		end
	end

endmodule

// ===== rtl/core/slu_queue.sv =====
// command queue between scanner and result expander
module slu_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  slu_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          nonempty,
	output slu_pkg::cmd_t head
);
	import slu_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign do_push  = push & ~full;
	assign do_pop   = pop & nonempty;
	assign head     = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_cmd;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/slu_back.sv =====
// back end: expands commands into result items through an output register
module slu_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_nonempty,
	input  slu_pkg::cmd_t q_head,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    out_byte,
	output logic          byte_valid,
	output logic          string_done,
	output logic          bad_start,
	output logic          run_last
);
	import slu_pkg::*;

	logic       act_q;
	cmd_t       cur_q;
	logic [1:0] idx_q;

	logic       valid_q;
	logic [7:0] byte_q;
	logic       bvalid_q, done_q, bad_q, last_q;

	cmd_t       src;
	logic [1:0] src_idx;
	logic       have, slot_free, step, is_last;
	logic [7:0] sel_byte;

	// pick the command being expanded
	assign src       = act_q ? cur_q : q_head;
	assign src_idx   = act_q ? idx_q : 2'd0;
	assign have      = act_q | q_nonempty;
	assign slot_free = ~valid_q | ~out_stall;
	assign step      = have & slot_free;
	assign is_last   = (src_idx == src.last_idx);
	assign pop       = step & ~act_q;

	always_comb begin
		case (src_idx)
			2'd0:    sel_byte = src.b0;
			2'd1:    sel_byte = src.b1;
			2'd2:    sel_byte = src.b2;
			default: sel_byte = 8'd0;
		endcase
	end

	// expansion control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			idx_q <= 2'd0;
		end else if (step) begin
			act_q <= ~is_last;
			idx_q <= src_idx + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) cur_q <= src;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= have;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			byte_q   <= sel_byte;
			bvalid_q <= src.byte_valid;
			done_q   <= src.string_done;
			bad_q    <= src.bad_start;
			last_q   <= is_last;
		end
	end

	assign out_valid   = valid_q;
	assign out_byte    = byte_q;
	assign byte_valid  = bvalid_q;
	assign string_done = done_q;
	assign bad_start   = bad_q;
	assign run_last    = last_q;

endmodule

// ===== rtl/core/string_literal_unescape_mutf8_core.sv =====
// String literal unescaper: quoted source bytes in, modified utf-8 bytes out.
//
// Input channel (in_valid/in_stall/in_char) takes one source byte per item,
// starting at the opening quote; a zero byte or closing quote ends a literal.
// Output channel (out_valid/out_stall/...) gives zero to three result items
// per source byte; run_last marks the final one of each source byte.
// Results pass the command queue, then the output register. One source byte
// is taken per cycle while in_stall is low; the result side moves one item
// per cycle while out_stall is low, so a \uXXXX escape needing three bytes
// holds the output for three items. The command queue (QUEUE_DEPTH entries)
// between scanner and expander soaks up these bursts; in_stall rises only
// when it is full. Stalling the output holds the current item steady and,
// once the queue fills, stalls the input. Reset puts the scanner in the idle
// mode awaiting an opening quote and empties the queue and output register.
module string_literal_unescape_mutf8_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_char,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       string_done,
	output logic       bad_start,
	output logic       run_last
);
	import slu_pkg::*;

	logic q_full, q_nonempty, push, pop;
	cmd_t push_cmd, q_head;

	// scanner
	slu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_char  (in_char),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// command queue
	slu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.nonempty (q_nonempty),
		.head     (q_head)
	);

	// result expander
	slu_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_nonempty  (q_nonempty),
		.q_head      (q_head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.string_done (string_done),
		.bad_start   (bad_start),
		.run_last    (run_last)
	);

endmodule
